[src/assert_macros.svh]
// Assertion macros used by the RTL core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, disabled in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/mbf_pkg.sv]
// Types and constants of the MAC blacklist filter table.
// No dependencies.
package mbf_pkg;
  localparam int MacW = 48;
  localparam int CntW = 64;
  localparam int CfgW = 7;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_DEL  = 3'd1,
    OP_UP   = 3'd2,
    OP_DOWN = 3'd3,
    OP_READ = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  // one table entry as held in memory
  typedef struct packed {
    logic [MacW-1:0] addr;
    logic [CntW-1:0] up;
    logic [CntW-1:0] down;
  } entry_t;
endpackage

[src/mbf_table_mem.sv]
// Entry memory of the filter table: one write port, one registered read port.
// Depends on mbf_pkg.
module mbf_table_mem
  import mbf_pkg::*;
#(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  entry_t           wdata,
  input  logic [AddrW-1:0] raddr,
  output entry_t           rdata
);
  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/mac_blacklist_filter_table_core.sv]
// Top level of the MAC blacklist filter table.
// Depends on mbf_pkg, mbf_table_mem and assert_macros.svh.
//
// Blocked addresses sit in one synchronous memory (address and both drop counters
// per entry); valid bits are flip-flops cleared at reset, so no clearing pass is
// needed. Each transfer on s_axis is handled alone: a scan reads every slot,
// starting at the hash bucket, through the single read port, one slot a cycle,
// looking for a match and the first free slot upward from the hash. The first scan
// cycle only primes the read port. Then the write-back state registers the entry
// update and loads the m_axis output register, raising m_axis_tvalid in the
// cycle after. A new input is taken only once the previous result has left on
// m_axis, so a stall on m_axis_tready holds off the next input.
// The user must write max_count on cfg only while idle; the block itself does not
// enforce this. Values above MAX_ENTRIES act as MAX_ENTRIES.
`include "assert_macros.svh"
module mac_blacklist_filter_table_core
  import mbf_pkg::*;
#(
  parameter int MAX_ENTRIES  = 64,
  parameter int HASH_BUCKETS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,   // mac[47:0]
  input  logic [2:0]   s_axis_tuser,   // opcode[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // drop, uplink_packets, downlink_packets,
                                       // entries_used
  output logic [1:0]   m_axis_tuser,   // status[1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data        // max_count
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int HW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_OUT} state_t;
  state_t state;

  logic [CfgW-1:0] max_count;
  logic [MAX_ENTRIES-1:0] valid;
  logic [NW-1:0] count;
  logic [2:0] op;
  logic [MacW-1:0] mac;
  logic [AW-1:0] raddr, rslot;
  logic [NW-1:0] issued;     // slots examined
  logic rd_pend;             // first read still in flight
  logic found, has_free;
  logic [AW-1:0] hit_slot, free_slot;
  entry_t hit_entry;
  entry_t rdata, wdata;
  logic we;
  logic [AW-1:0] waddr;

  // write-back values
  logic [1:0]             status_next;
  logic [128:0]           res_next;
  logic                   we_next;
  entry_t                 wdata_next;
  logic [AW-1:0]          waddr_next;
  logic [MAX_ENTRIES-1:0] valid_next;
  logic [NW-1:0]          count_next;

  // hash: sum of the three 16-bit words modulo HASH_BUCKETS, then modulo MAX_ENTRIES
  logic [17:0] hsum;
  logic [17:0] hmod;
  logic [AW-1:0] hstart;
  assign hsum = 18'(s_axis_tdata[47:32]) + 18'(s_axis_tdata[31:16])
              + 18'(s_axis_tdata[15:0]);
  assign hmod = 18'((hsum % 18'(HASH_BUCKETS)) % 18'(MAX_ENTRIES));
  assign hstart = hmod[AW-1:0];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    logic [AW:0] t;
    t = {1'b0, a} + 1'b1;
    wrap_inc = (t >= (AW+1)'(MAX_ENTRIES)) ? '0 : t[AW-1:0];
  endfunction

  mbf_table_mem #(.Depth(MAX_ENTRIES), .AddrW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  logic [NW-1:0] limit;
  assign limit = (NW'(max_count) < NW'(MAX_ENTRIES) && 32'(max_count) < MAX_ENTRIES)
               ? NW'(max_count) : NW'(MAX_ENTRIES);

  // outcome of the scan; full by count is checked before duplicate, duplicate before no free slot
  always_comb begin
    status_next = ST_OK;
    res_next    = '0;
    we_next     = 1'b0;
    wdata_next  = hit_entry;
    waddr_next  = hit_slot;
    valid_next  = valid;
    count_next  = count;
    case (op)
      OP_ADD: begin
        if (count >= limit) begin
          status_next = ST_FULL;
        end else if (found) begin
          status_next = ST_DUP;
        end else if (!has_free) begin
          status_next = ST_FULL;
        end else begin
          we_next = 1'b1;
          waddr_next = free_slot;
          wdata_next = '{addr: mac, up: '0, down: '0};
          valid_next[free_slot] = 1'b1;
          count_next = count + 1'b1;
        end
        // a present address reports its counters, full or not
        if (found) begin
          res_next[64:1] = hit_entry.up;
          res_next[128:65] = hit_entry.down;
        end
      end
      OP_DEL: begin
        if (found) begin
          valid_next[hit_slot] = 1'b0;
          if (count != '0) count_next = count - 1'b1;
        end else status_next = ST_ABSENT;
      end
      OP_UP, OP_DOWN: begin
        if (found) begin
          we_next = 1'b1;
          if (op == OP_UP) wdata_next.up = hit_entry.up + 1'b1;
          else wdata_next.down = hit_entry.down + 1'b1;
          res_next[0] = 1'b1;
          res_next[64:1] = wdata_next.up;
          res_next[128:65] = wdata_next.down;
        end else status_next = ST_ABSENT;
      end
      OP_READ: begin
        if (found) begin
          res_next[64:1] = hit_entry.up;
          res_next[128:65] = hit_entry.down;
        end else status_next = ST_ABSENT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
      max_count <= 7'd64;
      m_axis_tvalid <= 1'b0;
      we <= 1'b0;
    end else begin
      if (cfg_valid) max_count <= cfg_data;
      we <= (state == S_WRITE) && we_next;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op <= s_axis_tuser;
            mac <= s_axis_tdata[MacW-1:0];
            raddr <= hstart;
            issued <= NW'(1);
            rd_pend <= 1'b1;
            rslot <= hstart;
            found <= 1'b0;
            has_free <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            // first slot is being read this cycle
            rd_pend <= 1'b0;
            raddr <= wrap_inc(raddr);
          end else begin
            // examine slot read last cycle
            if (valid[rslot] && rdata.addr == mac && !found) begin
              found <= 1'b1;
              hit_slot <= rslot;
              hit_entry <= rdata;
            end
            if (!valid[rslot] && !has_free) begin
              has_free <= 1'b1;
              free_slot <= rslot;
            end
            if (issued == NW'(MAX_ENTRIES)) begin
              state <= S_WRITE;
            end else begin
              rslot <= wrap_inc(rslot);
              raddr <= wrap_inc(raddr);
              issued <= issued + 1'b1;
            end
          end
        end
        S_WRITE: begin
          waddr <= waddr_next;
          wdata <= wdata_next;
          valid <= valid_next;
          count <= count_next;
          m_axis_tuser <= status_next;
          m_axis_tdata <= {7'(count_next), res_next};
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_count_max, 1'b1, count <= NW'(MAX_ENTRIES))
  `ASSERT_IMPL(a_no_accept_busy, state != S_IDLE, !s_axis_tready)
  `ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
